### hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Round constants, initial hash values and the round helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned NumRounds  = 64;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned HashWords  = 8;
  localparam logic [7:0]  PadByte    = 8'h80;

  // Request codes.
  localparam logic ReqAbsorb   = 1'b0;
  localparam logic ReqFinalize = 1'b1;

  typedef logic [WordWidth-1:0] word_t;

  // Round constants, one per round.
  function automatic word_t round_const(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  // Initial hash values.
  function automatic word_t init_hash(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordWidth - n));
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

### hdl/sha256_ifs.sv
// ----------------------------------------------------------------------------
// SHA-256 stream channels
// Valid/ready interfaces for the request and the digest channels.
// ----------------------------------------------------------------------------
interface sha256_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  modport source (output valid, req_type, data_byte, input ready);
  modport sink (input valid, req_type, data_byte, output ready);
endinterface

interface sha256_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### hdl/sha256_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round datapath
// One compression round per cycle on the working variables a..h.
// ----------------------------------------------------------------------------
module sha256_round
  import sha256_pkg::*;
(
  input  word_t             k_i,
  input  word_t             w_i,
  input  word_t [7:0]       v_i,
  output word_t [7:0]       v_o
);

  word_t t1, t2, ch, maj;

  // Round function: t1 from e..h, t2 from a..c.
  always_comb begin
    ch    = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    maj   = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t1    = v_i[7] + big_sig1(v_i[4]) + ch + k_i + w_i;
    t2    = big_sig0(v_i[0]) + maj;
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
  end

endmodule

### hdl/sha256_stream_hash_core.sv
// ----------------------------------------------------------------------------
// SHA-256 streaming hash core
// Absorbs one message byte per request; finalize pads and emits the digest.
// ----------------------------------------------------------------------------
// An absorb request that carries the 64th byte of a block starts the
// compression: the core loads the working variables, runs 64 rounds and
// folds them into the hash, and it takes no new byte until the fold is
// done. The 16-entry message memory holds the block words and is read ahead
// through its registered read port during the first 16 rounds; the expanded
// schedule words come from a 16-word register window. A finalize request
// zero-fills the rest of the block one word per cycle, writes the bit length
// as word 14 then word 15 and runs one or two compressions (two when 56 or
// more bytes are pending), then presents the eight digest words, most
// significant first; the hash restarts from the initial values for the next
// message. Payload fields follow the request channel; a request is accepted
// when valid and ready are both high.
module sha256_stream_hash_core
  import sha256_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  sha256_req_if.sink           in_req,
  sha256_dig_if.source         out_dig
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_ROUND = 7'b0001000,
    ST_FOLD  = 7'b0010000,
    ST_LEN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t       state_r, state_nxt;
  word_t [7:0]  hash_r, hash_nxt;
  word_t [7:0]  vars_r, vars_nxt, vars_rnd;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  msg_r, msg_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic         fin_r, fin_nxt;       // compression is part of finalize
  logic         second_r, second_nxt; // a length-only block follows
  logic [3:0]   pad_r, pad_nxt;       // zero-fill word pointer
  logic [2:0]   oidx_r, oidx_nxt;

  // Message memory: block words, one write and one read port.
  word_t        mem [BlockWords];
  logic         mem_we;
  logic [3:0]   mem_wa, mem_ra;
  word_t        mem_wd, mem_rd;

  // Schedule taps kept in registers: w[t-16..t-1] sliding window shadow.
  word_t [15:0] win_r, win_nxt;
  word_t        w_cur;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd <= mem[mem_ra];
  end

  sha256_round u_round (
    .k_i (round_const(rnd_r)),
    .w_i (w_cur),
    .v_i (vars_r),
    .v_o (vars_rnd)
  );

  // Schedule word for this round: block word or expanded word.
  always_comb begin
    if (rnd_r < 6'd16) begin
      w_cur = mem_rd;
    end else begin
      w_cur = win_r[0] + small_sig0(win_r[1]) + win_r[9] + small_sig1(win_r[14]);
    end
  end

  logic in_fire, out_fire;
  assign in_fire  = in_req.valid && in_req.ready;
  assign out_fire = out_dig.valid && out_dig.ready;
  assign in_req.ready = (state_r == ST_IDLE);
  assign out_dig.valid = (state_r == ST_OUT);
  assign out_dig.digest_word = hash_r[oidx_r];
  assign out_dig.word_index  = oidx_r;
  assign out_dig.last_word   = (oidx_r == 3'd7);

  // Byte merge: the first byte of a word clears the rest.
  function automatic word_t merge(input word_t old, input logic [1:0] pos,
                                  input logic [7:0] b);
    word_t r;
    r = (pos == 2'd0) ? '0 : old;
    r[(3 - pos) * 8 +: 8] = b;
    return r;
  endfunction

  word_t cur_word_r, cur_word_nxt; // word under construction

  // Control and datapath sequencing.
  always_comb begin
    state_nxt    = state_r;
    hash_nxt     = hash_r;
    vars_nxt     = vars_r;
    fill_nxt     = fill_r;
    msg_nxt      = msg_r;
    rnd_nxt      = rnd_r;
    fin_nxt      = fin_r;
    second_nxt   = second_r;
    pad_nxt      = pad_r;
    oidx_nxt     = oidx_r;
    win_nxt      = win_r;
    cur_word_nxt = cur_word_r;
    mem_we       = 1'b0;
    mem_wa       = fill_r[5:2];
    mem_wd       = '0;
    mem_ra       = 4'd0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_req.req_type == ReqAbsorb) begin
          cur_word_nxt = merge(cur_word_r, fill_r[1:0], in_req.data_byte);
          mem_we  = 1'b1;
          mem_wd  = cur_word_nxt;
          msg_nxt = msg_r + 64'd1;
          fill_nxt = fill_r + 6'd1;
          fin_nxt = 1'b0;
          if (fill_r == 6'd63) begin
            state_nxt = ST_LOAD;
          end
        end else if (in_fire) begin
          // Pad byte into the current word, then zero the rest.
          cur_word_nxt = merge(cur_word_r, fill_r[1:0], PadByte);
          mem_we   = 1'b1;
          mem_wd   = cur_word_nxt;
          fin_nxt  = 1'b1;
          second_nxt = (fill_r >= 6'd56);
          pad_nxt  = fill_r[5:2] + 4'd1;
          state_nxt = (fill_r[5:2] == 4'd15) ? (second_nxt ? ST_LOAD : ST_LEN) : ST_PAD;
        end
      end
      ST_PAD: begin
        mem_we = 1'b1;
        mem_wa = pad_r;
        mem_wd = '0;
        pad_nxt = pad_r + 4'd1;
        if (pad_r == 4'd15) begin
          state_nxt = second_r ? ST_LOAD : ST_LEN;
        end
      end
      ST_LEN: begin
        // Two writes of the bit length, word 14 then word 15.
        mem_we = 1'b1;
        mem_wa = {3'b111, pad_r[0]};
        mem_wd = msg_r[60:29];
        if (pad_r[0]) begin
          mem_wd = {msg_r[28:0], 3'b000};
          state_nxt = ST_LOAD;
        end
        pad_nxt = {3'b000, ~pad_r[0]};
      end
      ST_LOAD: begin
        vars_nxt = hash_r;
        rnd_nxt  = 6'd0;
        mem_ra   = 4'd0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        vars_nxt = vars_rnd;
        win_nxt  = {w_cur, win_r[15:1]};
        mem_ra   = rnd_r[3:0] + 4'd1;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < HashWords; i++) begin
          hash_nxt[i] = hash_r[i] + vars_r[i];
        end
        if (fin_r && second_r) begin
          second_nxt = 1'b0;
          pad_nxt    = 4'd0;
          state_nxt  = ST_PAD;
        end else if (fin_r) begin
          oidx_nxt  = 3'd0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            for (int i = 0; i < HashWords; i++) begin
              hash_nxt[i] = init_hash(3'(i));
            end
            fill_nxt  = '0;
            msg_nxt   = '0;
            fin_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      msg_r    <= '0;
      fin_r    <= 1'b0;
      second_r <= 1'b0;
      oidx_r   <= '0;
      for (int i = 0; i < HashWords; i++) begin
        hash_r[i] <= init_hash(3'(i));
      end
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      msg_r    <= msg_nxt;
      fin_r    <= fin_nxt;
      second_r <= second_nxt;
      oidx_r   <= oidx_nxt;
      hash_r   <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vars_r     <= vars_nxt;
    rnd_r      <= rnd_nxt;
    pad_r      <= pad_nxt;
    win_r      <= win_nxt;
    cur_word_r <= cur_word_nxt;
  end

  // Checks on the sequencer.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> !out_dig.valid) else $error("ready while emitting");
  a_round_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> (state_r == ST_ROUND && rnd_r == 6'd0))
    else $error("round counter not cleared");
  a_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == 6'd63) |=> (state_r == ST_FOLD))
    else $error("missing fold");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_dig.last_word) |=> (fill_r == 6'd0 && msg_r == 64'd0))
    else $error("no restart after digest");

endmodule
